@@ sv/tcw_pkg.sv @@
// shared constants, codes and control types of the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // default frame geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // character handling
    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam logic [7:0] MAX_CODE  = 8'd127;
    localparam logic [3:0] TEXT_FG   = 4'h7;
    localparam logic [3:0] TEXT_BG   = 4'h0;

    // frame store write source
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_CLEAR = 3'd1;
    localparam logic [2:0] WR_COPY  = 3'd2;
    localparam logic [2:0] WR_ZERO  = 3'd3;
    localparam logic [2:0] WR_CHAR  = 3'd4;

    // frame store read source
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_CELL = 2'd1;
    localparam logic [1:0] RD_COPY = 2'd2;

    typedef struct packed {
        logic       accept;      // take the incoming item
        logic [2:0] wr_sel;
        logic [1:0] rd_sel;
        logic       copy_init;   // sweep starts at the second row
        logic       zero_init;   // sweep starts at the bottom row
        logic       sweep_step;
        logic       load_out;    // result goes into the output register
    } tcw_cmd_t;

    typedef struct packed {
        logic in_read;
        logic in_print;
        logic in_scroll;
        logic sweep_last;
        logic out_free;
    } tcw_sts_t;

endpackage

`default_nettype wire

@@ sv/tcw_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/tcw_ctrl.sv @@
// controller state machine of the text console writer
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t      cmd
);

    import tcw_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_sel     = WR_CLEAR;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_print)
                    begin
                        cmd.wr_sel = WR_CHAR;
                    end
                    if (sts.in_read)
                    begin
                        cmd.rd_sel = RD_CELL;
                    end
                    if (sts.in_scroll)
                    begin
                        cmd.copy_init = 1'b1;
                        state_next    = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_COPY:
            begin
                cmd.rd_sel     = RD_COPY;
                cmd.wr_sel     = WR_COPY;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last copied cell lands here
                cmd.wr_sel    = WR_COPY;
                cmd.zero_init = 1'b1;
                state_next    = ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.wr_sel     = WR_ZERO;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/tcw_datapath.sv @@
// cursor, frame store, sweep counter and output register of the text console writer
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tcw_pkg::tcw_cmd_t                cmd,
    output tcw_pkg::tcw_sts_t                     sts,
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tcw_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ADDR_W-1:0] base_reg;       // row_reg * COLUMNS
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] cp_addr_reg;    // destination of the cell in flight
    logic              cp_pend_reg;
    logic              written_reg;
    logic              rd_ok_reg;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [7:0]        code;
    logic [10:0]       idx;
    logic              is_lf;
    logic              code_ok;
    logic              last_row;
    logic              col_ok;
    logic              is_send;

    logic              char_we;
    logic              colr_we;
    logic [ADDR_W-1:0] char_waddr;
    logic [ADDR_W-1:0] colr_waddr;
    logic [7:0]        char_wdata;
    logic [7:0]        colr_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        char_rdata;
    logic [7:0]        colr_rdata;
    logic [7:0]        out_char;
    logic [7:0]        out_colr;

    assign code     = s_tdata[7:0];
    assign idx      = s_tdata[18:8];
    assign is_lf    = (code == LINE_FEED);
    assign code_ok  = (code <= MAX_CODE);
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign col_ok   = (col_reg < COL_W'(COLUMNS));
    assign is_send  = !s_tuser && code_ok;

    assign sts.in_read    = s_tuser;
    assign sts.in_print   = is_send && !is_lf && col_ok;
    assign sts.in_scroll  = is_send && is_lf && last_row;
    assign sts.sweep_last = (sweep_reg == ADDR_W'(CELLS - 1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // cursor and request flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            base_reg    <= '0;
            written_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            written_reg <= is_send && (is_lf || col_ok);
            rd_ok_reg   <= s_tuser && (32'(idx) < CELLS);
            if (is_send && is_lf)
            begin
                col_reg <= '0;
                if (!last_row)
                begin
                    row_reg  <= row_reg + 1'b1;
                    base_reg <= base_reg + ADDR_W'(COLUMNS);
                end
            end
            else if (is_send && col_ok)
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // sweep counter for clearing and scrolling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg   <= '0;
            cp_pend_reg <= 1'b0;
            cp_addr_reg <= '0;
        end
        else
        begin
            if (cmd.copy_init)
            begin
                sweep_reg <= ADDR_W'(COLUMNS);
            end
            else if (cmd.zero_init)
            begin
                sweep_reg <= ADDR_W'(CELLS - COLUMNS);
            end
            else if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            cp_pend_reg <= (cmd.rd_sel == RD_COPY);
            cp_addr_reg <= sweep_reg - ADDR_W'(COLUMNS);
        end
    end

    // frame store port steering
    always_comb
    begin
        char_we    = 1'b0;
        colr_we    = 1'b0;
        char_waddr = sweep_reg;
        colr_waddr = sweep_reg;
        char_wdata = '0;
        colr_wdata = '0;
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                char_we = 1'b1;
                colr_we = 1'b1;
            end
            WR_COPY:
            begin
                char_we    = cp_pend_reg;
                colr_we    = cp_pend_reg;
                char_waddr = cp_addr_reg;
                colr_waddr = cp_addr_reg;
                char_wdata = char_rdata;
                colr_wdata = colr_rdata;
            end
            WR_ZERO:
            begin
                // bottom row keeps its colours
                char_we = 1'b1;
            end
            WR_CHAR:
            begin
                char_we    = 1'b1;
                colr_we    = 1'b1;
                char_waddr = base_reg + ADDR_W'(col_reg);
                colr_waddr = base_reg + ADDR_W'(col_reg);
                char_wdata = code;
                colr_wdata = {TEXT_FG, TEXT_BG};
            end
            default:
            begin
                char_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = sweep_reg;
        case (cmd.rd_sel)
            RD_CELL:
            begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(idx);
            end
            RD_COPY:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (char_we),
        .wr_addr (char_waddr),
        .wr_data (char_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (char_rdata)
    );

    // colour byte: foreground high nibble, background low nibble
    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_colr_ram (
        .clk     (clk),
        .wr_en   (colr_we),
        .wr_addr (colr_waddr),
        .wr_data (colr_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (colr_rdata)
    );

    assign out_char = rd_ok_reg ? char_rdata : 8'h00;
    assign out_colr = rd_ok_reg ? colr_rdata : 8'h00;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {3'b000, written_reg, 7'(col_reg), 5'(row_reg),
                            out_colr[3:0], out_colr[7:4], out_char};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS))
        else $error("cursor column beyond line end");

    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) == 32'(row_reg) * COLUMNS)
        else $error("row base out of step with cursor row");

    a_copy_vs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cp_pend_reg |-> (cmd.wr_sel == WR_COPY))
        else $error("copied cell dropped by another write");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a waiting item");

endmodule

`default_nettype wire

@@ sv/text_console_writer.sv @@
// top level of the text console writer: frame store console with cursor
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  signals                    contents
// s_axis    in   s_tvalid s_tready          s_tdata: char_code, cell_index; s_tuser: req_type
// m_axis    out  m_tvalid m_tready          m_tdata: read_char .. written
//
// a plain send or a read is accepted, then loaded into the result register once it is free
// a line feed on the bottom row scrolls: a copy pass moving the lower rows up a row,
// a drain state and a pass to blank the bottom characters, one cell per cycle
// through the single write port of each frame store ram
// after reset a clearing pass over all ROWS*COLUMNS cells (2000 by default) runs
// before the first item is taken
// a stalled result sits in the output register while the next item is accepted

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] req_type (0 send, 1 read)
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] read_char, [11:8] read_fg, [15:12] read_bg, [20:16] cursor_row_out,
    // [27:21] cursor_col_out, [28] written, [31:29] zero
    output logic      [tcw_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import tcw_pkg::*;

    // commands from the controller, status back from the datapath
    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the text console writer: random text, scrolls and cell reads
`timescale 1ns / 1ps

module testbench;

    import tcw_pkg::*;

    localparam int COLS        = DEF_COLUMNS;
    localparam int ROWS_N      = DEF_ROWS;
    localparam int CELLS       = COLS * ROWS_N;
    localparam int RESULT_W    = 29;
    localparam int TOTAL_ITEMS = 1650;
    localparam int CALM_ITEMS  = 200;      // tail of the run with no idling
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    // a scroll is (ROWS-1)*COLUMNS copies plus a drain and a bottom-row blank
    localparam int DRAIN_CYCLES = CELLS + 200;
    localparam int LIMIT       = 4_000_000;

    localparam bit REQ_SEND = 1'b0;
    localparam bit REQ_READ = 1'b1;

    // result fields from the msb down, matching m_tdata[28:0]
    typedef struct packed {
        logic       written;
        logic [6:0] col;
        logic [4:0] row;
        logic [3:0] bg;
        logic [3:0] fg;
        logic [7:0] ch;
    } console_result_t;

    // keeps its own copy of the frame store and cursor and queues the expected results
    class console_scoreboard;
        bit [7:0]        glyph   [CELLS];
        bit [3:0]        fg_mem  [CELLS];
        bit [3:0]        bg_mem  [CELLS];
        int              row;
        int              col;
        console_result_t expected_results[$];
        int              mismatches;
        int              sends;
        int              reads;
        int              scrolls;
        int              dropped;
        int              ignored;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                glyph[i]  = '0;
                fg_mem[i] = '0;
                bg_mem[i] = '0;
            end
            row        = 0;
            col        = 0;
            mismatches = 0;
            sends      = 0;
            reads      = 0;
            scrolls    = 0;
            dropped    = 0;
            ignored    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // apply one accepted item to the console state and queue its result
        function void note_item(bit req, bit [7:0] code, bit [10:0] idx);
            console_result_t r;
            int              pos;
            r = '0;
            if (req == REQ_READ)
            begin
                reads++;
                // out-of-range reads return zero cell data
                if (idx < CELLS)
                begin
                    r.ch = glyph[idx];
                    r.fg = fg_mem[idx];
                    r.bg = bg_mem[idx];
                end
            end
            else
            begin
                sends++;
                if (code > MAX_CODE)
                    ignored++;
                else if (code == LINE_FEED)
                begin
                    col       = 0;
                    r.written = 1'b1;
                    if (row + 1 >= ROWS_N)
                    begin
                        // scroll: everything up one row, bottom chars blanked, colors kept
                        scrolls++;
                        for (int i = 0; i < CELLS - COLS; i++)
                        begin
                            glyph[i]  = glyph[i + COLS];
                            fg_mem[i] = fg_mem[i + COLS];
                            bg_mem[i] = bg_mem[i + COLS];
                        end
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            glyph[i] = '0;
                        row = ROWS_N - 1;
                    end
                    else
                        row++;
                end
                else if (col >= COLS)
                    dropped++;    // line full, no wrap
                else
                begin
                    pos         = row * COLS + col;
                    glyph[pos]  = code;
                    fg_mem[pos] = TEXT_FG;
                    bg_mem[pos] = TEXT_BG;
                    col++;
                    r.written = 1'b1;
                end
            end
            r.row = row[4:0];
            r.col = col[6:0];
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            console_result_t got;
            console_result_t want;
            got = data[RESULT_W-1:0];
            if (expected_results.size() == 0)
            begin
                $error("result 0x%h arrived with nothing expected", data);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_char", want.ch, got.ch);
            compare_field("read_fg", want.fg, got.fg);
            compare_field("read_bg", want.bg, got.bg);
            compare_field("cursor_row_out", want.row, got.row);
            compare_field("cursor_col_out", want.col, got.col);
            compare_field("written", want.written, got.written);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // [7:0] char_code, [18:8] cell_index
    logic                  s_tuser;     // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // [7:0] read_char .. [28] written

    console_scoreboard sb;
    int                items_sent;
    int                cycle_count;
    bit                idle_on;       // random idling on both sides
    bit                hold_request;  // asks the receiver for one long hold-off

    text_console_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // input side monitor: every accepted item goes to the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[7:0], s_tdata[18:8]);
    end

    // output side monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: ready runs, random stall bursts, and one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // offer one item and hold it until taken; valid stays high on return
    task automatic send_item(input bit req, input bit [7:0] code, input bit [10:0] idx);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'd0, idx, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // cell_index is a don't-care on sends, so keep it random
    task automatic send_char(input bit [7:0] code);
        send_item(REQ_SEND, code, 11'($urandom_range(0, 2047)));
    endtask

    // char_code is a don't-care on reads
    task automatic read_cell(input bit [10:0] idx);
        send_item(REQ_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    // let a clock edge pass first so the last accepted item is already queued
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly cells anywhere, some on the cursor row, some past the end of the store
    function automatic bit [10:0] pick_cell();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 11'($urandom_range(0, CELLS - 1));
        else if (pick < 85)
            return 11'(sb.row * COLS + $urandom_range(0, COLS - 1));
        else
            return 11'($urandom_range(CELLS, 2047));
    endfunction

    // one line of text with reads and stray high codes mixed in, usually closed by a line feed
    task automatic write_line();
        int len;
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 45)
            len = $urandom_range(0, 10);
        else if (kind < 85)
            len = $urandom_range(11, 60);
        else
            len = $urandom_range(78, 100);    // near or past the line length
        for (int k = 0; k < len && items_sent < TOTAL_ITEMS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_char(8'($urandom_range(0, MAX_CODE)));
            else if (pick < 78)
                send_char(8'($urandom_range(MAX_CODE + 1, 255)));
            else
                read_cell(pick_cell());
        end
        if (items_sent < TOTAL_ITEMS && $urandom_range(0, 9) < 8)
            send_char(LINE_FEED);
    endtask

    initial
    begin
        bit hold_done;
        bit pause_done;

        sb           = new();
        items_sent   = 0;
        cycle_count  = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_SEND;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: cleared store, read range edges, code edges, ignored fields
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'h7FF);
        send_char(8'h41);
        send_char(8'h00);
        send_char(MAX_CODE);
        send_char(MAX_CODE + 8'd1);
        send_char(8'hFF);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);
        read_cell(11'd3);
        send_char(LINE_FEED);
        send_item(REQ_SEND, 8'h7E, 11'h7FF);
        send_item(REQ_READ, 8'hFF, 11'(COLS));
        send_item(REQ_READ, 8'h0A, 11'd1024);
        send_item(REQ_SEND, 8'h55, 11'd0);
        send_char(LINE_FEED);
        read_cell(11'(COLS + 1));
        wait_drained();

        // random text sessions
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            if (!hold_done && items_sent >= 700)
            begin
                // receiver stalls long while reads keep coming, so the input backs up
                hold_done    = 1'b1;
                idle_on      = 1'b0;
                hold_request = 1'b1;
                repeat (20)
                    read_cell(pick_cell());
                idle_on = 1'b1;
            end
            if (!pause_done && items_sent >= 1100)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            write_line();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items: %0d sends, %0d reads, %0d scrolls", items_sent, sb.sends,
                 sb.reads, sb.scrolls);
        $display("%0d chars dropped on a full line, %0d high codes ignored", sb.dropped,
                 sb.ignored);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
